FILE: design/ccrrg_pkg.sv
`timescale 1ns / 1ps

package ccrrg_pkg;

  localparam int unsigned NUM_STREAMS_DEF = 3;
  localparam int unsigned WORDS = 6;

  typedef enum logic [0:0] {
    OP_DRAW   = 1'b0,
    OP_RESEED = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_WBACK,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } st_e;

  typedef struct packed {
    op_e                operation;
    logic        [1:0]  stream;
    logic        [31:0] seed_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [31:0] logic_base_seed;
  } out_t;

  // per-word seed offsets
  function automatic logic [31:0] seed_ofs(input logic [2:0] k);
    logic [31:0] ofs;
    case (k)
      3'd0:    ofs = 32'hf22d0e56;
      3'd1:    ofs = 32'h883126e9;
      3'd2:    ofs = 32'hc624dd2f;
      3'd3:    ofs = 32'h0702c49c;
      3'd4:    ofs = 32'h9e353f7d;
      3'd5:    ofs = 32'h6fdf3b64;
      default: ofs = 32'h0;
    endcase
    return ofs;
  endfunction

endpackage

FILE: design/ccrrg_ram.sv
`timescale 1ns / 1ps

module ccrrg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 18
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/carry_chain_random_range_generator.sv
// steps: a reseed of a known stream writes its six words; a draw with zero span or
// unknown stream, or a reseed of an unknown stream, goes straight to the result; a full
// draw does 6 word reads, 6 write backs, 32 restoring remainder steps of one bit each,
// 1 add, 1 output load; throughput: one item at a time, in_stall_o stays high until the
// result is loaded into the output register, which can be held off by out_stall_i
// reset: every generator reads as seeded with zero until first written, base seed 0
`timescale 1ns / 1ps

module carry_chain_random_range_generator #(
  parameter int unsigned NumStreams = ccrrg_pkg::NUM_STREAMS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ccrrg_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ccrrg_pkg::out_t out_data_o
);

  import ccrrg_pkg::*;

  localparam int unsigned Depth = NumStreams * WORDS;
  localparam int unsigned AW = $clog2(Depth);

  st_e                   state_q, state_d;
  in_t                   item_q, item_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [31:0]           span_q, span_d;
  logic [31:0]           acc_q, acc_d;
  logic                  carry_q, carry_d;
  logic                  ripple_q, ripple_d;
  logic [31:0]           sr_q [WORDS];
  logic [31:0]           sr_d [WORDS];
  logic [31:0]           rem_q, rem_d;
  logic [31:0]           quo_q, quo_d;
  logic [31:0]           res_q, res_d;
  logic [31:0]           base_q, base_d;
  logic [NumStreams-1:0] row_vld_q, row_vld_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [2:0]            rd_k_q, rd_k_d;
  out_t                  out_q, out_d;
  logic                  out_vld_q, out_vld_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [31:0]           ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [31:0]           ram_rdata;

  logic [AW-1:0]         base_addr;
  logic                  row_vld;
  logic                  in_ok;
  logic [31:0]           span_in;
  logic [NumStreams-1:0] row_mask;

  ccrrg_ram #(
    .Width(32),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign base_addr = AW'({30'b0, item_q.stream} * WORDS);
  assign row_mask  = NumStreams'(1) << item_q.stream;
  assign row_vld   = |(row_vld_q & row_mask);
  assign in_ok     = {30'b0, in_data_i.stream} < NumStreams;
  assign span_in   = in_data_i.range_high - in_data_i.range_low + 32'd1;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [31:0] word;
    logic [32:0] sum33;
    logic [31:0] push_val;
    logic        push;
    logic [31:0] wb_val;
    logic [32:0] trial;

    state_d   = state_q;
    item_d    = item_q;
    cnt_d     = cnt_q;
    span_d    = span_q;
    acc_d     = acc_q;
    carry_d   = carry_q;
    ripple_d  = ripple_q;
    sr_d      = sr_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    res_d     = res_q;
    base_d    = base_q;
    row_vld_d = row_vld_q;
    rd_vld_d  = 1'b0;
    rd_k_d    = rd_k_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    ram_we    = 1'b0;
    ram_waddr = base_addr;
    ram_wdata = 32'h0;
    ram_raddr = base_addr;
    word      = 32'h0;
    sum33     = 33'h0;
    push_val  = 32'h0;
    push      = 1'b0;
    wb_val    = 32'h0;
    trial     = 33'h0;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          span_d = span_in;
          cnt_d  = 5'd0;
          if (in_data_i.operation == OP_RESEED) begin
            if (in_ok) begin
              state_d = ST_SEED;
              if (in_data_i.stream == 2'd0) begin
                base_d = in_data_i.seed_value;
              end
            end else begin
              res_d   = 32'h0;
              state_d = ST_DONE;
            end
          end else if (span_in == 32'h0 || !in_ok) begin
            res_d   = in_data_i.range_high;
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = base_addr + AW'(cnt_q[2:0]);
        ram_wdata = item_q.seed_value + seed_ofs(cnt_q[2:0]);
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == 5'(WORDS - 1)) begin
          row_vld_d = row_vld_q | row_mask;
          res_d     = 32'h0;
          state_d   = ST_DONE;
        end
      end
      ST_READ: begin
        // words are fetched from the top word down
        if (cnt_q < 5'(WORDS)) begin
          ram_raddr = base_addr + AW'(3'(WORDS - 1) - cnt_q[2:0]);
          rd_vld_d  = 1'b1;
          rd_k_d    = 3'(WORDS - 1) - cnt_q[2:0];
          cnt_d     = cnt_q + 5'd1;
        end
        if (rd_vld_q) begin
          word = row_vld ? ram_rdata : seed_ofs(rd_k_q);
          push = 1'b1;
          case (rd_k_q)
            3'd5: begin
              acc_d    = word;
              push_val = word;
            end
            3'd4: begin
              sum33    = {1'b0, acc_q} + {1'b0, word};
              acc_d    = sum33[31:0];
              carry_d  = sum33[32];
              push_val = sum33[31:0];
            end
            default: begin
              push_val = acc_q + word + {31'b0, carry_q};
              acc_d    = push_val;
              carry_d  = (push_val < word);
            end
          endcase
          if (rd_k_q == 3'd0) begin
            state_d  = ST_WBACK;
            cnt_d    = 5'd0;
            ripple_d = 1'b1;
          end
        end
        if (push) begin
          for (int i = 0; i < WORDS - 1; i++) begin
            sr_d[i] = sr_q[i+1];
          end
          sr_d[WORDS-1] = push_val;
        end
      end
      ST_WBACK: begin
        // increment with ripple, top word first
        wb_val    = sr_q[0] + {31'b0, ripple_q};
        ram_we    = 1'b1;
        ram_waddr = base_addr + AW'(3'(WORDS - 1) - cnt_q[2:0]);
        ram_wdata = wb_val;
        ripple_d  = ripple_q & (wb_val == 32'h0);
        for (int i = 0; i < WORDS - 1; i++) begin
          sr_d[i] = sr_q[i+1];
        end
        sr_d[WORDS-1] = 32'h0;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(WORDS - 1)) begin
          row_vld_d = row_vld_q | row_mask;
          quo_d     = wb_val;
          rem_d     = 32'h0;
          cnt_d     = 5'd0;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        trial = {rem_q, quo_q[31]};
        if (trial >= {1'b0, span_q}) begin
          rem_d = 32'(trial - {1'b0, span_q});
        end else begin
          rem_d = trial[31:0];
        end
        quo_d = {quo_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        res_d   = rem_q + item_q.range_low;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d.value           = res_q;
          out_d.logic_base_seed = base_q;
          out_vld_d             = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= 5'd0;
      base_q    <= 32'h0;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      base_q    <= base_d;
      row_vld_q <= row_vld_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    span_q   <= span_d;
    acc_q    <= acc_d;
    carry_q  <= carry_d;
    ripple_q <= ripple_d;
    sr_q     <= sr_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    res_q    <= res_d;
    rd_k_q   <= rd_k_d;
    out_q    <= out_d;
  end

  // remainder stays below the span
  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < span_q))
    else $error("remainder not below span");

  // generator only advances for a nonzero span
  a_read_nonzero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (span_q != 32'h0))
    else $error("advance started with zero span");

  // zero span draw returns range_high at once
  a_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.operation == OP_DRAW && span_in == 32'h0)
    |=> (state_q == ST_DONE && res_q == $past(in_data_i.range_high)))
    else $error("zero span draw mishandled");

  // finished result moves to the output register when it is free
  a_done_unload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !(out_vld_q && out_stall_i))
    |=> (out_vld_q && state_q == ST_IDLE))
    else $error("result not loaded");

endmodule

FILE: bench/carry_chain_random_range_generator_tb.sv
`timescale 1ns / 1ps

module carry_chain_random_range_generator_tb;
  import ccrrg_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int NUM_GEN = NUM_STREAMS_DEF;
  localparam int NUM_RANDOM = 800;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int DRAIN_AT = 400;
  localparam int MAX_PRINTED = 32;
  // word 5 loads as all ones, so the next draw wraps it
  localparam logic [31:0] WRAP_SEED = 32'h9020c49b;
  localparam logic [31:0] WORD_OFS [WORDS] = '{
    32'hf22d0e56, 32'h883126e9, 32'hc624dd2f, 32'h0702c49c, 32'h9e353f7d, 32'h6fdf3b64
  };

  typedef struct packed {
    op_e         op;
    logic [1:0]  stream;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        known;
    logic [31:0] value;
    logic [31:0] base;
  } row_t;

  typedef struct {
    in_t  item;
    bit   known;
    out_t known_res;
    bit   drain_first;
  } stim_t;

  localparam int NUM_DIRECTED = 24;
  localparam row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{OP_DRAW,   2'd0, 32'h0,        32'h00000000, 32'hffffffff, 1'b1, 32'hffffffff, 32'h0},
    '{OP_DRAW,   2'd3, 32'h0,        32'h00000005, 32'h0000000a, 1'b1, 32'h0000000a, 32'h0},
    '{OP_RESEED, 2'd3, 32'hdeadbeef, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 32'h0},
    '{OP_DRAW,   2'd1, 32'h0,        32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 32'h0},
    '{OP_DRAW,   2'd0, 32'h0,        32'h80000000, 32'h7fffffff, 1'b1, 32'h7fffffff, 32'h0},
    '{OP_DRAW,   2'd0, 32'h0,        32'h00000000, 32'h7ffffffe, 1'b0, 32'h0,        32'h0},
    '{OP_DRAW,   2'd1, 32'h0,        32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff, 32'h0},
    '{OP_DRAW,   2'd2, 32'h0,        32'h00000064, 32'h00000032, 1'b0, 32'h0,        32'h0},
    '{OP_RESEED, 2'd0, 32'hffffffff, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000,
      32'hffffffff},
    '{OP_DRAW,   2'd0, 32'h0,        32'h80000000, 32'h80000000, 1'b1, 32'h80000000,
      32'hffffffff},
    '{OP_DRAW,   2'd0, 32'h0,        32'hfffffff6, 32'h0000000a, 1'b0, 32'h0,        32'h0},
    '{OP_RESEED, 2'd1, 32'h0,        32'h00000000, 32'h00000000, 1'b1, 32'h00000000,
      32'hffffffff},
    '{OP_DRAW,   2'd1, 32'h0,        32'h00000000, 32'h00000001, 1'b0, 32'h0,        32'h0},
    '{OP_RESEED, 2'd2, WRAP_SEED,    32'h00000000, 32'h00000000, 1'b1, 32'h00000000,
      32'hffffffff},
    '{OP_DRAW,   2'd2, 32'h0,        32'h00000000, 32'h0000ffff, 1'b0, 32'h0,        32'h0},
    '{OP_DRAW,   2'd2, 32'h0,        32'h00000000, 32'h0000ffff, 1'b0, 32'h0,        32'h0},
    '{OP_DRAW,   2'd2, 32'h0,        32'h7fffffff, 32'h80000000, 1'b0, 32'h0,        32'h0},
    '{OP_DRAW,   2'd3, 32'h0,        32'h00000000, 32'h00000000, 1'b1, 32'h00000000,
      32'hffffffff},
    '{OP_RESEED, 2'd0, 32'h0,        32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 32'h0},
    '{OP_DRAW,   2'd0, 32'h0,        32'h00000001, 32'h40000000, 1'b0, 32'h0,        32'h0},
    '{OP_DRAW,   2'd1, 32'h0,        32'h80000000, 32'h7ffffffe, 1'b0, 32'h0,        32'h0},
    '{OP_DRAW,   2'd2, 32'h0,        32'h7fffffff, 32'h7fffffff, 1'b1, 32'h7fffffff, 32'h0},
    '{OP_RESEED, 2'd1, 32'ha5a5a5a5, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 32'h0},
    '{OP_DRAW,   2'd1, 32'h0,        32'h00000000, 32'hfffffffe, 1'b0, 32'h0,        32'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  logic [31:0] gen_words [NUM_GEN][WORDS];
  logic [31:0] logic_seed;
  out_t        expected_results [$];
  stim_t       stimulus [$];

  int cycle_count = 0;
  int error_count = 0;
  int result_count = 0;
  int draw_count = 0;
  int passthrough_count = 0;
  int reseed_count = 0;
  int word5_wraps = 0;

  carry_chain_random_range_generator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("carry_chain_random_range_generator_tb: FAIL");
    $finish;
  end

  function automatic void load_generator(int g, logic [31:0] seed);
    int k;
    for (k = 0; k < WORDS; k++) begin
      gen_words[g][k] = seed + WORD_OFS[k];
    end
  endfunction

  function automatic logic [31:0] advance_generator(int g);
    logic [31:0] acc;
    logic [31:0] other;
    logic        carry;
    logic        bump;
    int          k;
    acc = gen_words[g][5] + gen_words[g][4];
    carry = (acc < gen_words[g][5]) || (acc < gen_words[g][4]);
    gen_words[g][4] = acc;
    for (k = 3; k >= 0; k--) begin
      other = gen_words[g][k];
      acc = acc + other + 32'(carry);
      carry = acc < other;
      gen_words[g][k] = acc;
    end
    // increment word 5 with ripple toward word 1, then into word 0 and the sum
    k = 5;
    bump = 1'b1;
    while (bump && k >= 1) begin
      gen_words[g][k] = gen_words[g][k] + 32'd1;
      bump = gen_words[g][k] == 32'd0;
      if (k == 5 && bump) word5_wraps++;
      k--;
    end
    if (bump) begin
      gen_words[g][0] = gen_words[g][0] + 32'd1;
      acc = acc + 32'd1;
    end
    return acc;
  endfunction

  function automatic out_t predict_result(in_t item);
    out_t        res;
    logic [31:0] span;
    logic [31:0] drawn;
    int          g;
    res = '0;
    g = int'(item.stream);
    if (item.operation == OP_RESEED) begin
      reseed_count++;
      if (g < NUM_GEN) begin
        load_generator(g, item.seed_value);
        if (g == 0) logic_seed = item.seed_value;
      end
    end else begin
      draw_count++;
      span = item.range_high - item.range_low + 32'd1;
      if (span == 32'd0 || g >= NUM_GEN) begin
        passthrough_count++;
        res.value = item.range_high;
      end else begin
        drawn = advance_generator(g);
        res.value = (drawn % span) + item.range_low;
      end
    end
    res.logic_base_seed = logic_seed;
    return res;
  endfunction

  function automatic in_t random_item();
    in_t item;
    item.operation = ($urandom_range(0, 9) == 0) ? OP_RESEED : OP_DRAW;
    item.stream = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: item.seed_value = WRAP_SEED - 32'($urandom_range(0, 3));
      1: item.seed_value = 32'($urandom_range(0, 15));
      default: item.seed_value = $urandom;
    endcase
    item.range_low = $urandom;
    case ($urandom_range(0, 7))
      0: item.range_high = item.range_low - 32'sd1;
      1: item.range_high = item.range_low + 32'($urandom_range(0, 15));
      4: begin
        item.range_low = 32'($urandom_range(0, 100));
        item.range_high = item.range_low + $urandom;
      end
      5: begin
        item.range_low = 32'h80000000 + 32'($urandom_range(0, 3));
        item.range_high = 32'h7fffffff - 32'($urandom_range(0, 3));
      end
      6: item.range_high = item.range_low;
      7: begin
        item.range_low = -32'($urandom_range(0, 1000));
        item.range_high = 32'($urandom_range(0, 1000));
      end
      default: item.range_high = $urandom;
    endcase
    return item;
  endfunction

  function automatic int draw_wait(int n);
    if ((n / 64) % 4 == 1) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] result %0d: %s got %h expected %h", $time, result_count, what, got,
               exp_val);
    end
    error_count++;
  endtask

  // receiver: random hold-off per result, one long hold to back up the block
  initial begin
    int   hold;
    out_t exp_res;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = (result_count == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_wait(result_count);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer, value", out_data_o.value, 32'h0);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data_o.value !== exp_res.value) begin
          report_mismatch("value", out_data_o.value, exp_res.value);
        end
        if (out_data_o.logic_base_seed !== exp_res.logic_base_seed) begin
          report_mismatch("logic_base_seed", out_data_o.logic_base_seed,
                          exp_res.logic_base_seed);
        end
      end
      result_count++;
    end
  end

  initial begin
    stim_t entry;
    int    gap;
    int    n;
    for (n = 0; n < WORDS * NUM_GEN; n++) begin
      gen_words[n / WORDS][n % WORDS] = WORD_OFS[n % WORDS];
    end
    logic_seed = '0;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      entry.item.operation = DIRECTED_ROWS[n].op;
      entry.item.stream = DIRECTED_ROWS[n].stream;
      entry.item.seed_value = DIRECTED_ROWS[n].seed;
      entry.item.range_low = DIRECTED_ROWS[n].lo;
      entry.item.range_high = DIRECTED_ROWS[n].hi;
      entry.known = DIRECTED_ROWS[n].known;
      entry.known_res.value = DIRECTED_ROWS[n].value;
      entry.known_res.logic_base_seed = DIRECTED_ROWS[n].base;
      entry.drain_first = 1'b0;
      stimulus.push_back(entry);
    end
    for (n = 0; n < NUM_RANDOM; n++) begin
      entry.item = random_item();
      entry.known = 1'b0;
      entry.known_res = '0;
      entry.drain_first = (n == 0) || (n == DRAIN_AT);
      stimulus.push_back(entry);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < stimulus.size(); n++) begin
      gap = draw_wait(n);
      if (stimulus[n].drain_first) begin
        in_valid_i <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end else if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i <= stimulus[n].item;
      do @(posedge clk_i); while (in_stall_o);
      entry.known_res = predict_result(stimulus[n].item);
      expected_results.push_back(stimulus[n].known ? stimulus[n].known_res : entry.known_res);
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d items: %0d draws (%0d zero span or unknown stream), %0d reseeds",
             stimulus.size(), draw_count, passthrough_count, reseed_count);
    $display("word 5 wrapped %0d times, %0d results checked, %0d mismatches", word5_wraps,
             result_count, error_count);
    if (error_count == 0) begin
      $display("carry_chain_random_range_generator_tb: PASS");
    end else begin
      $display("carry_chain_random_range_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
